// ----- rtl/fhfi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// fhfi_pkg: shared types, field widths, register indexes and helpers
// for the floor heat flux integrator; no dependencies

package fhfi_pkg;

  localparam int TEMP_W     = 18;
  localparam int FLUX_W     = 18;
  localparam int UVAL_W     = 16;
  localparam int FCAP_W     = 24;
  localparam int ACAP_W     = 20;
  localparam int STEP_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // raw flux, raw flux sum and scaled numerators
  localparam int PFLUX_W    = 35;
  localparam int XF_W       = 48;
  localparam int XA_W       = 47;
  localparam int FNUM_W     = 39;
  localparam int QUO_W      = 20;
  localparam int SAT_W      = 22;
  localparam int MEAN_SHIFT = 14;
  localparam int RAW_SHIFT  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_U_AIR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_U_SOIL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_CAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_CAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd4;

  localparam logic [UVAL_W-1:0] U_AIR_RST     = 16'd1920;
  localparam logic [UVAL_W-1:0] U_SOIL_RST    = 16'd1920;
  localparam logic [FCAP_W-1:0] FLOOR_CAP_RST = 24'd42000;
  localparam logic [ACAP_W-1:0] AIR_CAP_RST   = 20'd4790;
  localparam logic [STEP_W-1:0] STEP_RST      = 12'd120;

  localparam logic signed [TEMP_W-1:0] FLOOR_TEMP_RST = 18'sd18432;

  localparam logic signed [SAT_W-1:0] TEMP_HI = 22'sd131071;
  localparam logic signed [SAT_W-1:0] TEMP_LO = -22'sd131072;

  typedef struct packed {
    logic load_in;
    logic start_ndiv;
    logic load_n;
    logic load_den;
    logic mul_flux;
    logic mul_step;
    logic start_sub;
    logic update_sub;
    logic start_mean;
    logic load_out;
  } fhfi_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_sub;
  } fhfi_sts_t;

  function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [SAT_W-1:0] v);
    logic signed [TEMP_W-1:0] r;
    priority if (v > TEMP_HI) begin
      r = TEMP_HI[TEMP_W-1:0];
    end else if (v < TEMP_LO) begin
      r = TEMP_LO[TEMP_W-1:0];
    end else begin
      r = v[TEMP_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/floor_heat_flux_integrator.sv -----
// floor_heat_flux_integrator: top level with configuration registers,
// sequencer and datapath; uses fhfi_pkg, fhfi_ctrl, fhfi_datapath
//
// Input channel: in_valid_i/in_stall_o with indoor_temp_i and soil_temp_i.
// A transaction is taken only while the block is free; in_stall_o stays high
// from acceptance until the result has been placed in the output register.
// Output channel: out_valid_o/out_stall_i with floor_temp_o and mean_flux_o.
// The output register holds one result, so a new input is taken while it
// waits; the next result is held internally until the register is free.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high and indexes past step_seconds are dropped.
// The run time grows with the substep count n and is set by the
// bit-serial divider (20 quotient bits, one per cycle) run once for the
// substep count, once per substep and once for the mean flux. At the reset
// settings n = 7; n is at most MAX_SUBSTEPS (181 by default).
// Reset puts the registers at their reset values, the floor temperature at
// 18 degrees C and both channels empty. A stalled receiver only holds the
// result; the block keeps its state.
`timescale 1ns / 1ps
`default_nettype none

module floor_heat_flux_integrator #(
  parameter int unsigned MAX_SUBSTEP  = 20,
  parameter int unsigned MAX_SUBSTEPS = 181
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [fhfi_pkg::TEMP_W-1:0]    indoor_temp_i,
  input  wire logic signed [fhfi_pkg::TEMP_W-1:0]    soil_temp_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [fhfi_pkg::TEMP_W-1:0]         floor_temp_o,
  output logic signed [fhfi_pkg::FLUX_W-1:0]         mean_flux_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [fhfi_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [fhfi_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  logic [fhfi_pkg::UVAL_W-1:0] u_air_q, u_soil_q;
  logic [fhfi_pkg::FCAP_W-1:0] floor_cap_q;
  logic [fhfi_pkg::ACAP_W-1:0] air_cap_q;
  logic [fhfi_pkg::STEP_W-1:0] step_q;

  fhfi_pkg::fhfi_cmd_t cmd;
  fhfi_pkg::fhfi_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_air_q     <= fhfi_pkg::U_AIR_RST;
      u_soil_q    <= fhfi_pkg::U_SOIL_RST;
      floor_cap_q <= fhfi_pkg::FLOOR_CAP_RST;
      air_cap_q   <= fhfi_pkg::AIR_CAP_RST;
      step_q      <= fhfi_pkg::STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fhfi_pkg::CFG_U_AIR:     u_air_q     <= cfg_data_i[fhfi_pkg::UVAL_W-1:0];
        fhfi_pkg::CFG_U_SOIL:    u_soil_q    <= cfg_data_i[fhfi_pkg::UVAL_W-1:0];
        fhfi_pkg::CFG_FLOOR_CAP: floor_cap_q <= cfg_data_i[fhfi_pkg::FCAP_W-1:0];
        fhfi_pkg::CFG_AIR_CAP:   air_cap_q   <= cfg_data_i[fhfi_pkg::ACAP_W-1:0];
        fhfi_pkg::CFG_STEP:      step_q      <= cfg_data_i[fhfi_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fhfi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fhfi_datapath #(
    .MAX_SUBSTEP  (MAX_SUBSTEP),
    .MAX_SUBSTEPS (MAX_SUBSTEPS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .u_air_i       (u_air_q),
    .u_soil_i      (u_soil_q),
    .floor_cap_i   (floor_cap_q),
    .air_cap_i     (air_cap_q),
    .step_i        (step_q),
    .indoor_temp_i (indoor_temp_i),
    .soil_temp_i   (soil_temp_i),
    .floor_temp_o  (floor_temp_o),
    .mean_flux_o   (mean_flux_o)
  );

endmodule

`default_nettype wire

// ----- rtl/fhfi_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// fhfi_div: unsigned restoring divider, one quotient bit per cycle
// quotient saturates to all ones when it does not fit; uses fhfi_pkg

module fhfi_div #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [NUM_W-1:0]           num_i,
  input  wire logic [DEN_W-1:0]           den_i,
  output logic                            done_o,
  output logic [fhfi_pkg::QUO_W-1:0]      quo_o
);

  localparam int QW    = fhfi_pkg::QUO_W;
  localparam int DSH_W = DEN_W + QW - 1;
  localparam int CMP_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int CNT_W = $clog2(QW);

  logic [NUM_W-1:0] rem_q, rem_d;
  logic [DSH_W-1:0] dsh_q, dsh_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic             ovf_q, ovf_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [CMP_W-1:0] rem_ext, dsh_ext, diff;
  logic             fits;

  assign rem_ext = CMP_W'(rem_q);
  assign dsh_ext = CMP_W'(dsh_q);
  assign fits    = (rem_ext >= dsh_ext);
  assign diff    = rem_ext - dsh_ext;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = DSH_W'(den_i) << (QW - 1);
      quo_d  = '0;
      ovf_d  = (CMP_W'(num_i >> QW) >= CMP_W'(den_i));
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QW - 1);
    end else if (busy_q) begin
      rem_d = fits ? diff[NUM_W-1:0] : rem_q;
      dsh_d = dsh_q >> 1;
      quo_d = {quo_q[QW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign done_o = done_q;
  assign quo_o  = ovf_q ? '1 : quo_q;

endmodule

`default_nettype wire

// ----- rtl/fhfi_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// fhfi_datapath: flux multipliers, substep update, flux sum and result registers
// uses fhfi_pkg and two fhfi_div instances

module fhfi_datapath #(
  parameter int unsigned MAX_SUBSTEP  = 20,
  parameter int unsigned MAX_SUBSTEPS = 181
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire fhfi_pkg::fhfi_cmd_t                     cmd_i,
  output fhfi_pkg::fhfi_sts_t                          sts_o,
  input  wire logic [fhfi_pkg::UVAL_W-1:0]             u_air_i,
  input  wire logic [fhfi_pkg::UVAL_W-1:0]             u_soil_i,
  input  wire logic [fhfi_pkg::FCAP_W-1:0]             floor_cap_i,
  input  wire logic [fhfi_pkg::ACAP_W-1:0]             air_cap_i,
  input  wire logic [fhfi_pkg::STEP_W-1:0]             step_i,
  input  wire logic signed [fhfi_pkg::TEMP_W-1:0]      indoor_temp_i,
  input  wire logic signed [fhfi_pkg::TEMP_W-1:0]      soil_temp_i,
  output logic signed [fhfi_pkg::TEMP_W-1:0]           floor_temp_o,
  output logic signed [fhfi_pkg::FLUX_W-1:0]           mean_flux_o
);

  localparam int TW     = fhfi_pkg::TEMP_W;
  localparam int PW     = fhfi_pkg::PFLUX_W;
  localparam int XFW    = fhfi_pkg::XF_W;
  localparam int XAW    = fhfi_pkg::XA_W;
  localparam int QW     = fhfi_pkg::QUO_W;
  localparam int SW     = fhfi_pkg::SAT_W;
  localparam int NWB    = $clog2(MAX_SUBSTEPS + 1);
  localparam int DEN_W  = NWB + fhfi_pkg::FCAP_W;
  localparam int SUM_W  = PW + NWB;
  localparam int MNUM_W = SUM_W - 1 - fhfi_pkg::MEAN_SHIFT;
  localparam int NUM_W  = (MNUM_W > fhfi_pkg::FNUM_W) ? MNUM_W : fhfi_pkg::FNUM_W;

  logic signed [TW-1:0]    tin_q, tsoil_q, tf_q, floor_state_q;
  logic signed [TW-1:0]    floor_out_q, mean_out_q;
  logic [NWB-1:0]          n_q, sub_cnt_q;
  logic [DEN_W-1:0]        den_f_q, den_a_q;
  logic signed [PW-1:0]    p_soil_q, p_air_q;
  logic signed [XFW-1:0]   x_f_q;
  logic signed [XAW-1:0]   x_a_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    neg_f_q, neg_a_q, neg_m_q;

  logic [fhfi_pkg::FCAP_W-1:0] cf_eff;
  logic [fhfi_pkg::ACAP_W-1:0] ca_eff;
  logic signed [TW:0]          d_soil, d_air;
  logic signed [PW:0]          p_soil_full, p_air_full, p_sum;
  logic signed [XFW:0]         x_f_full;
  logic signed [XAW:0]         x_a_full;
  logic signed [XFW-1:0]       mag_f;
  logic signed [XAW-1:0]       mag_a;
  logic signed [SUM_W-1:0]     mag_m;

  logic             start_a, start_b, done_a, done_b;
  logic [NUM_W-1:0] num_a, num_b;
  logic [DEN_W-1:0] den_a_in, den_b_in;
  logic [QW-1:0]    quo_a, quo_b;

  logic signed [SW-1:0] tf_ext, tin_ext, qa_ext, qb_ext;
  logic signed [SW-1:0] tf_new, tin_new, mean_new;

  assign cf_eff = (floor_cap_i == '0) ? fhfi_pkg::FCAP_W'(1) : floor_cap_i;
  assign ca_eff = (air_cap_i == '0) ? fhfi_pkg::ACAP_W'(1) : air_cap_i;

  assign d_soil = {tf_q[TW-1], tf_q} - {tsoil_q[TW-1], tsoil_q};
  assign d_air  = {tf_q[TW-1], tf_q} - {tin_q[TW-1], tin_q};
  assign p_soil_full = $signed({1'b0, u_soil_i}) * d_soil;
  assign p_air_full  = $signed({1'b0, u_air_i}) * d_air;

  assign p_sum    = {p_soil_q[PW-1], p_soil_q} + {p_air_q[PW-1], p_air_q};
  assign x_f_full = p_sum * $signed({1'b0, step_i});
  assign x_a_full = p_air_q * $signed({1'b0, step_i});

  assign mag_f = x_f_q[XFW-1] ? -x_f_q : x_f_q;
  assign mag_a = x_a_q[XAW-1] ? -x_a_q : x_a_q;
  assign mag_m = sum_q[SUM_W-1] ? -sum_q : sum_q;

  assign start_a = cmd_i.start_ndiv | cmd_i.start_sub | cmd_i.start_mean;
  assign start_b = cmd_i.start_sub;

  always_comb begin
    priority if (cmd_i.start_ndiv) begin
      num_a    = NUM_W'(step_i);
      den_a_in = DEN_W'(MAX_SUBSTEP);
    end else if (cmd_i.start_sub) begin
      num_a    = NUM_W'(mag_f[XFW-2:fhfi_pkg::RAW_SHIFT]);
      den_a_in = den_f_q;
    end else begin
      num_a    = NUM_W'(mag_m[SUM_W-2:fhfi_pkg::MEAN_SHIFT]);
      den_a_in = DEN_W'(n_q);
    end
  end

  assign num_b    = NUM_W'(mag_a[XAW-2:fhfi_pkg::RAW_SHIFT]);
  assign den_b_in = den_a_q;

  fhfi_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div_floor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_a),
    .num_i   (num_a),
    .den_i   (den_a_in),
    .done_o  (done_a),
    .quo_o   (quo_a)
  );

  fhfi_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div_air (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_b),
    .num_i   (num_b),
    .den_i   (den_b_in),
    .done_o  (done_b),
    .quo_o   (quo_b)
  );

  assign tf_ext  = SW'(tf_q);
  assign tin_ext = SW'(tin_q);
  assign qa_ext  = $signed({{(SW - QW){1'b0}}, quo_a});
  assign qb_ext  = $signed({{(SW - QW){1'b0}}, quo_b});

  // floor loses the signed quotient, local air gains it
  assign tf_new   = neg_f_q ? tf_ext + qa_ext : tf_ext - qa_ext;
  assign tin_new  = neg_a_q ? tin_ext - qb_ext : tin_ext + qb_ext;
  assign mean_new = neg_m_q ? -qa_ext : qa_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_state_q <= fhfi_pkg::FLOOR_TEMP_RST;
      sub_cnt_q     <= '0;
    end else begin
      if (cmd_i.load_den) begin
        sub_cnt_q <= '0;
      end else if (cmd_i.update_sub) begin
        sub_cnt_q <= sub_cnt_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        floor_state_q <= tf_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      tin_q   <= indoor_temp_i;
      tsoil_q <= soil_temp_i;
      tf_q    <= floor_state_q;
    end
    if (cmd_i.load_n) begin
      if (quo_a >= QW'(MAX_SUBSTEPS)) begin
        n_q <= NWB'(MAX_SUBSTEPS);
      end else begin
        n_q <= NWB'(quo_a + 1'b1);
      end
    end
    if (cmd_i.load_den) begin
      den_f_q <= DEN_W'(n_q) * DEN_W'(cf_eff);
      den_a_q <= DEN_W'(n_q) * DEN_W'(ca_eff);
      sum_q   <= '0;
    end
    if (cmd_i.mul_flux) begin
      p_soil_q <= p_soil_full[PW-1:0];
      p_air_q  <= p_air_full[PW-1:0];
    end
    if (cmd_i.mul_step) begin
      x_f_q <= x_f_full[XFW-1:0];
      x_a_q <= x_a_full[XAW-1:0];
      sum_q <= sum_q + SUM_W'(p_air_q);
    end
    if (cmd_i.start_sub) begin
      neg_f_q <= x_f_q[XFW-1];
      neg_a_q <= x_a_q[XAW-1];
    end
    if (cmd_i.start_mean) begin
      neg_m_q <= sum_q[SUM_W-1];
    end
    if (cmd_i.update_sub) begin
      tf_q  <= fhfi_pkg::sat_temp(tf_new);
      tin_q <= fhfi_pkg::sat_temp(tin_new);
    end
    if (cmd_i.load_out) begin
      floor_out_q <= tf_q;
      mean_out_q  <= fhfi_pkg::sat_temp(mean_new);
    end
  end

  assign sts_o.div_done = done_a | done_b;
  assign sts_o.last_sub = (sub_cnt_q == NWB'(n_q - 1'b1));

  assign floor_temp_o = floor_out_q;
  assign mean_flux_o  = mean_out_q;

endmodule

`default_nettype wire

// ----- rtl/fhfi_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// fhfi_ctrl: sequencer for substep count, substep loop, mean and output slot
// uses fhfi_pkg command and status types

module fhfi_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire fhfi_pkg::fhfi_sts_t  sts_i,
  output fhfi_pkg::fhfi_cmd_t       cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_NDIV  = 4'd1;
  localparam logic [3:0] ST_DEN   = 4'd2;
  localparam logic [3:0] ST_MUL1  = 4'd3;
  localparam logic [3:0] ST_MUL2  = 4'd4;
  localparam logic [3:0] ST_SDIV  = 4'd5;
  localparam logic [3:0] ST_SWAIT = 4'd6;
  localparam logic [3:0] ST_MEAN  = 4'd7;
  localparam logic [3:0] ST_MWAIT = 4'd8;
  localparam logic [3:0] ST_HOLD  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in    = 1'b1;
          cmd_o.start_ndiv = 1'b1;
          state_d          = ST_NDIV;
        end
      end
      ST_NDIV: begin
        if (sts_i.div_done) begin
          cmd_o.load_n = 1'b1;
          state_d      = ST_DEN;
        end
      end
      ST_DEN: begin
        cmd_o.load_den = 1'b1;
        state_d        = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_flux = 1'b1;
        state_d        = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_step = 1'b1;
        state_d        = ST_SDIV;
      end
      ST_SDIV: begin
        cmd_o.start_sub = 1'b1;
        state_d         = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.update_sub = 1'b1;
          state_d          = sts_i.last_sub ? ST_MEAN : ST_MUL1;
        end
      end
      ST_MEAN: begin
        cmd_o.start_mean = 1'b1;
        state_d          = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (sts_i.div_done) begin
          if (slot_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for floor_heat_flux_integrator, with a scoreboard class
// that integrates the floor temperature per substep; depends on fhfi_pkg and the rtl top

module tb_top;
  import fhfi_pkg::*;

  localparam int SUBSTEP_SECONDS = 20;
  localparam int SUBSTEP_LIMIT   = 181;
  localparam int FLUX_DIVISOR    = 16384;
  localparam int STALL_LIMIT     = 30000;
  localparam int DRAIN_CYCLES    = 5000;
  localparam int IDLE_PCT        = 34;
  localparam int CFG_SPARE_FIRST = int'(CFG_STEP) + 1;
  localparam int CFG_IDX_MAX     = (1 << CFG_IDX_W) - 1;

  localparam logic signed [TEMP_W-1:0] T_TOP    = 18'sh1FFFF;
  localparam logic signed [TEMP_W-1:0] T_BOTTOM = 18'sh20000;

  typedef struct {
    logic signed [TEMP_W-1:0] floor_temp;
    logic signed [FLUX_W-1:0] mean_flux;
  } floor_result_t;

  class floor_scoreboard;
    bit [UVAL_W-1:0] u_air;
    bit [UVAL_W-1:0] u_soil;
    bit [FCAP_W-1:0] floor_cap;
    bit [ACAP_W-1:0] air_cap;
    bit [STEP_W-1:0] step_s;
    longint floor_t;
    floor_result_t expected_q[$];
    int items;
    int results;
    int errors;

    function new();
      u_air     = U_AIR_RST;
      u_soil    = U_SOIL_RST;
      floor_cap = FLOOR_CAP_RST;
      air_cap   = AIR_CAP_RST;
      step_s    = STEP_RST;
      floor_t   = 18432;
    endfunction

    function longint clamp_temp(longint v);
      if (v > longint'(T_TOP)) return longint'(T_TOP);
      if (v < longint'(T_BOTTOM)) return longint'(T_BOTTOM);
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_U_AIR:     u_air = data[UVAL_W-1:0];
        CFG_U_SOIL:    u_soil = data[UVAL_W-1:0];
        CFG_FLOOR_CAP: floor_cap = data[FCAP_W-1:0];
        CFG_AIR_CAP:   air_cap = data[ACAP_W-1:0];
        CFG_STEP:      step_s = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // explicit euler over n substeps, divisions truncate toward zero
    function void note_temps(logic signed [TEMP_W-1:0] indoor, logic signed [TEMP_W-1:0] soil);
      longint air_t, soil_t, stepv, n, cf, ca, den_f, den_a, p_soil, p_air, sum, tf, mean;
      int k;
      floor_result_t r;
      air_t = indoor;
      soil_t = soil;
      stepv = longint'(step_s);
      n = stepv / SUBSTEP_SECONDS + 1;
      if (n > SUBSTEP_LIMIT) n = SUBSTEP_LIMIT;
      cf = (floor_cap == 0) ? 1 : longint'(floor_cap);
      ca = (air_cap == 0) ? 1 : longint'(air_cap);
      den_f = n * cf * 256;
      den_a = n * ca * 256;
      sum = 0;
      tf = floor_t;
      for (k = 0; k < n; k++) begin
        p_soil = longint'(u_soil) * (tf - soil_t);
        p_air = longint'(u_air) * (tf - air_t);
        tf = clamp_temp(tf - ((p_soil + p_air) * stepv) / den_f);
        air_t = clamp_temp(air_t + (p_air * stepv) / den_a);
        sum += p_air;
      end
      floor_t = tf;
      mean = clamp_temp(sum / (n * FLUX_DIVISOR));
      r.floor_temp = tf[TEMP_W-1:0];
      r.mean_flux = mean[FLUX_W-1:0];
      expected_q.push_back(r);
      items++;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 50) $display("mismatch: %s", what);
    endtask

    task check_result(logic signed [TEMP_W-1:0] ft, logic signed [FLUX_W-1:0] mf);
      floor_result_t e;
      results++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result floor %0d flux %0d", ft, mf));
        return;
      end
      e = expected_q.pop_front();
      if (ft !== e.floor_temp)
        report_mismatch($sformatf("result %0d floor_temp %0d, want %0d", results, ft,
                                  e.floor_temp));
      if (mf !== e.mean_flux)
        report_mismatch($sformatf("result %0d mean_flux %0d, want %0d", results, mf,
                                  e.mean_flux));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [TEMP_W-1:0] indoor_temp_i;
  logic signed [TEMP_W-1:0] soil_temp_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [TEMP_W-1:0] floor_temp_o;
  logic signed [FLUX_W-1:0] mean_flux_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  floor_scoreboard sb;
  bit steady;
  int settings_used;
  int stuck_cycles;

  floor_heat_flux_integrator #(
    .MAX_SUBSTEP (SUBSTEP_SECONDS),
    .MAX_SUBSTEPS(SUBSTEP_LIMIT)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .indoor_temp_i(indoor_temp_i),
    .soil_temp_i  (soil_temp_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .floor_temp_o (floor_temp_o),
    .mean_flux_o  (mean_flux_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side: check accepted transactions, random stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(floor_temp_o, mean_flux_o);
      out_stall_i <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", stuck_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_temps(logic signed [TEMP_W-1:0] indoor, logic signed [TEMP_W-1:0] soil);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    indoor_temp_i <= indoor;
    soil_temp_i <= soil;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sb.note_temps(indoor, soil);
  endtask

  task automatic finish_batch();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(int idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx[CFG_IDX_W-1:0];
    cfg_data_i <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    sb.write_reg(idx[CFG_IDX_W-1:0], data);
  endtask

  task automatic program_registers(logic [CFG_DATA_W-1:0] ua, logic [CFG_DATA_W-1:0] us,
                                   logic [CFG_DATA_W-1:0] fc, logic [CFG_DATA_W-1:0] ac,
                                   logic [CFG_DATA_W-1:0] st);
    cfg_write(CFG_U_AIR, ua);
    cfg_write(CFG_U_SOIL, us);
    cfg_write(CFG_FLOOR_CAP, fc);
    cfg_write(CFG_AIR_CAP, ac);
    cfg_write(CFG_STEP, st);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [TEMP_W-1:0] rand_temp();
    logic [31:0] bits;
    int v;
    int r;
    r = $urandom_range(0, 99);
    bits = $urandom;
    if (r < 10) begin
      case (bits[1:0])
        2'd0: return T_TOP;
        2'd1: return T_BOTTOM;
        2'd2: return '0;
        default: return '1;
      endcase
    end
    if (r < 40) return bits[TEMP_W-1:0];
    // roughly -10 to 40 degrees C
    v = int'($urandom_range(0, 51200)) - 10240;
    return v[TEMP_W-1:0];
  endfunction

  initial begin
    int p;
    int k;
    int count;
    int idx;
    logic [CFG_DATA_W-1:0] ua, us, fc, ac, st;

    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    indoor_temp_i = '0;
    soil_temp_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, field extremes
    send_temps(T_TOP, T_TOP);
    send_temps(T_BOTTOM, T_BOTTOM);
    send_temps(T_TOP, T_BOTTOM);
    send_temps(T_BOTTOM, T_TOP);
    send_temps('0, '0);
    send_temps(-18'sd1, 18'sd1);
    send_temps(18'sd21504, 18'sd10240);
    send_temps(18'sd18432, 18'sd18432);
    finish_batch();

    // spare indexes must be dropped
    for (idx = CFG_SPARE_FIRST; idx <= CFG_IDX_MAX; idx++) cfg_write(idx, '1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);

    // zero capacities, maximum u-values: floor and flux saturate
    program_registers('1, '1, '0, '0, 24'd1);
    send_temps(T_TOP, T_BOTTOM);
    send_temps(T_BOTTOM, T_TOP);
    send_temps(T_BOTTOM, T_BOTTOM);
    send_temps(T_TOP, T_TOP);
    send_temps('0, '0);
    finish_batch();

    // zero step
    program_registers(24'd1920, 24'd1920, 24'd42000, 24'd4790, 24'd0);
    send_temps(T_TOP, T_BOTTOM);
    send_temps(18'sd1024, -18'sd1024);
    send_temps(T_BOTTOM, T_TOP);
    finish_batch();

    // substep count clipped
    program_registers(24'd3000, 24'd500, 24'd1, '1, '1);
    send_temps(18'sd20480, 18'sd5120);
    send_temps(T_BOTTOM, T_TOP);
    send_temps(T_TOP, 18'sd0);
    finish_batch();

    for (p = 0; p < 12; p++) begin
      steady = (p == 3 || p == 8);
      case (p % 4)
        0: begin
          ua = $urandom_range(128, 4096);
          us = $urandom_range(128, 4096);
          fc = $urandom_range(5000, 200000);
          ac = $urandom_range(1000, 20000);
        end
        1: begin
          ua = $urandom;
          us = $urandom;
          fc = $urandom;
          ac = $urandom;
        end
        2: begin
          ua = $urandom_range(0, 1) ? 24'hFFFF : 24'h0;
          us = $urandom_range(0, 1) ? 24'hFFFF : 24'h0;
          case ($urandom_range(0, 2))
            0: fc = 24'h0;
            1: fc = 24'h1;
            default: fc = 24'hFFFFFF;
          endcase
          case ($urandom_range(0, 2))
            0: ac = 24'h0;
            1: ac = 24'h1;
            default: ac = 24'hFFFFF;
          endcase
        end
        default: begin
          ua = $urandom_range(20000, 65535);
          us = $urandom_range(20000, 65535);
          fc = $urandom_range(0, 50);
          ac = $urandom_range(0, 50);
        end
      endcase
      count = 65;
      if (p == 5) begin
        st = 24'd3600;
        count = 6;
      end else if (p == 10) begin
        st = $urandom_range(1000, 4095);
        count = 6;
      end else if (p == 6) begin
        st = $urandom_range(0, 1000);
      end else begin
        st = $urandom_range(0, 199);
      end
      program_registers(ua, us, fc, ac, st);
      for (k = 0; k < count; k++) send_temps(rand_temp(), rand_temp());
      finish_batch();
    end
    steady = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
    $display("drove %0d temperature pairs under %0d register settings plus reset values",
             sb.items, settings_used);
    $display("compared %0d results, %0d mismatches", sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fhfi_pkg.sv
rtl/fhfi_div.sv
rtl/fhfi_datapath.sv
rtl/fhfi_ctrl.sv
rtl/floor_heat_flux_integrator.sv
dv/tb_top.sv
